/* src/sscp_pkg.sv */
// Shared widths, quotient classification type and helpers for the segment closest-point block.
`timescale 1ns / 1ps
package sscp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W = 16;
    localparam int POINT_W = 32;
    localparam int PARAM_W = 17;
    localparam int DIST_W = 49;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int SUM_W = 35;
    localparam int MAG_W = 34;

    typedef enum logic [1:0] {
        QK_ZERO,
        QK_ONE,
        QK_DIV
    } quo_kind_t;

    function automatic logic [MAG_W-1:0] mag_f(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] neg;
        neg = -v;
        return v[SUM_W-1] ? MAG_W'(neg) : MAG_W'(v);
    endfunction

    // A clamped quotient is zero for opposite signs, one when the magnitude
    // of the numerator reaches the denominator, and a true fraction otherwise.
    function automatic quo_kind_t quo_kind_f(input logic signed [SUM_W-1:0] n,
                                             input logic signed [SUM_W-1:0] d);
        quo_kind_t kind;
        if (n == '0) begin
            kind = QK_ZERO;
        end else if (n[SUM_W-1] != d[SUM_W-1]) begin
            kind = QK_ZERO;
        end else if (mag_f(n) >= mag_f(d)) begin
            kind = QK_ONE;
        end else begin
            kind = QK_DIV;
        end
        return kind;
    endfunction

endpackage

/* src/sscp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
`timescale 1ns / 1ps
module sscp_div #(
    parameter int DEN_W = sscp_pkg::MAG_W,
    parameter int QUO_W = sscp_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);
    localparam int REM_W = DEN_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [REM_W-1:0]  rem_reg [QUO_W-1];
    logic [DEN_W-1:0]  den_reg [QUO_W-1];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_in;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [QUO_W-1:0]  quo_next;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign side_cur = side_in;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign side_cur = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign trial = REM_W'(den_in) << (QUO_W - 1 - i);
        assign take = (rem_in >= trial);

        always_comb
        begin
            quo_next = quo_in;
            quo_next[QUO_W-1-i] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= quo_next;
                side_reg[i] <= side_cur;
            end
        end

        if (i < QUO_W - 1) begin : g_keep
            logic [REM_W-1:0] rem_next;
            assign rem_next = take ? (rem_in - trial) : rem_in;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo = quo_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

/* src/segment_segment_closest_points_top.sv */
// Closest points between two 2D segments: a fully pipelined datapath around three dividers.
// Throughput is one transfer per cycle in and out; a stalled valid output holds the whole pipeline.
// Reset clears only the valid bits; payload registers are not reset.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module segment_segment_closest_points_top #(
    parameter int FRAC_BITS = sscp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sscp_pkg::COORD_W-1:0] first_start_x,
    input  logic signed [sscp_pkg::COORD_W-1:0] first_start_y,
    input  logic signed [sscp_pkg::COORD_W-1:0] first_end_x,
    input  logic signed [sscp_pkg::COORD_W-1:0] first_end_y,
    input  logic signed [sscp_pkg::COORD_W-1:0] second_start_x,
    input  logic signed [sscp_pkg::COORD_W-1:0] second_start_y,
    input  logic signed [sscp_pkg::COORD_W-1:0] second_end_x,
    input  logic signed [sscp_pkg::COORD_W-1:0] second_end_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sscp_pkg::POINT_W-1:0] point_one_x,
    output logic signed [sscp_pkg::POINT_W-1:0] point_one_y,
    output logic signed [sscp_pkg::POINT_W-1:0] point_two_x,
    output logic signed [sscp_pkg::POINT_W-1:0] point_two_y,
    output logic [sscp_pkg::PARAM_W-1:0]        param_first,
    output logic [sscp_pkg::PARAM_W-1:0]        param_second,
    output logic [sscp_pkg::DIST_W-1:0]         dist_squared
);
    import sscp_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int QF = F + 1;
    localparam int NW = SUM_W + QF + 2;
    localparam int MUL_W = DIFF_W + QF + 1;
    localparam int CW = DIFF_W + QF + 2;
    localparam int DXW = CW + 1;
    localparam int HW = DXW - F;
    localparam int WW = 2 * HW + F + 1;
    localparam int DSW = WW + 1;
    localparam logic [QF-1:0] ONE_Q = {1'b1, {F{1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic signed [DIFF_W-1:0]  d1x;
        logic signed [DIFF_W-1:0]  d1y;
        logic signed [DIFF_W-1:0]  d2x;
        logic signed [DIFF_W-1:0]  d2y;
    } geo_t;

    typedef struct packed {
        geo_t                     g;
        logic signed [DIFF_W-1:0] rx;
        logic signed [DIFF_W-1:0] ry;
    } st1_t;

    typedef struct packed {
        geo_t                     g;
        logic signed [PROD_W-1:0] aa1;
        logic signed [PROD_W-1:0] aa2;
        logic signed [PROD_W-1:0] ee1;
        logic signed [PROD_W-1:0] ee2;
        logic signed [PROD_W-1:0] ff1;
        logic signed [PROD_W-1:0] ff2;
        logic signed [PROD_W-1:0] cc1;
        logic signed [PROD_W-1:0] cc2;
        logic signed [PROD_W-1:0] bb1;
        logic signed [PROD_W-1:0] bb2;
        logic signed [PROD_W-1:0] xa;
        logic signed [PROD_W-1:0] xb;
        logic signed [PROD_W-1:0] ya;
        logic signed [PROD_W-1:0] yb;
    } st2_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] f;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] cr12;
        logic signed [SUM_W-1:0] cr2r;
    } st3_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] f;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] b;
        logic                    az;
        logic                    ez;
        quo_kind_t               kind;
    } side1_t;

    typedef struct packed {
        side1_t             sd;
        logic [MAG_W+F-1:0] num;
        logic [MAG_W-1:0]   den;
    } st4_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] b;
        logic                    az;
        logic                    ez;
        logic [QF-1:0]           s0;
        logic signed [SUM_W+QF:0]  prod;
        logic signed [SUM_W+F-1:0] fsh;
    } st5_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] b;
        logic                    az;
        logic                    ez;
        logic [QF-1:0]           s0;
        logic signed [NW-1:0]    n;
    } st6_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] b;
        logic                    az;
        logic                    ez;
        logic                    low;
        logic                    high;
        logic                    neg;
        logic [QF-1:0]           s0;
    } side2_t;

    typedef struct packed {
        side2_t              sd;
        logic [MAG_W+QF-1:0] num;
        logic [MAG_W-1:0]    den;
    } st7_t;

    typedef struct packed {
        geo_t                    g;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] num3;
        logic [QF-1:0]           s0;
        logic [QF-1:0]           t;
        logic                    sel3;
    } st8_t;

    typedef struct packed {
        geo_t          g;
        logic [QF-1:0] s0;
        logic [QF-1:0] t;
        logic          sel3;
        quo_kind_t     kind;
    } side3_t;

    typedef struct packed {
        side3_t             sd;
        logic [MAG_W+F-1:0] num;
        logic [MAG_W-1:0]   den;
    } st9_t;

    typedef struct packed {
        geo_t          g;
        logic [QF-1:0] s;
        logic [QF-1:0] t;
    } st10_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic [QF-1:0]             s;
        logic [QF-1:0]             t;
        logic signed [MUL_W-1:0]   m1x;
        logic signed [MUL_W-1:0]   m1y;
        logic signed [MUL_W-1:0]   m2x;
        logic signed [MUL_W-1:0]   m2y;
    } st11_t;

    typedef struct packed {
        logic [QF-1:0]        s;
        logic [QF-1:0]        t;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic signed [CW-1:0] c2x;
        logic signed [CW-1:0] c2y;
    } pts_t;

    typedef struct packed {
        pts_t                  p;
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
    } st13_t;

    typedef struct packed {
        pts_t          p;
        logic [HW-1:0] hx;
        logic [HW-1:0] hy;
        logic [F-1:0]  lx;
        logic [F-1:0]  ly;
    } st14_t;

    typedef struct packed {
        pts_t              p;
        logic [2*HW-1:0]   hhx;
        logic [2*HW-1:0]   hhy;
        logic [HW+F-1:0]   hlx;
        logic [HW+F-1:0]   hly;
        logic [2*F-1:0]    llx;
        logic [2*F-1:0]    lly;
    } st15_t;

    typedef struct packed {
        pts_t          p;
        logic [WW-1:0] wx;
        logic [WW-1:0] wy;
        logic [2*F:0]  lsum;
    } st16_t;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg, v16_reg;
    logic out_valid_reg;

    st1_t  st1_reg, st1_next;
    st2_t  st2_reg, st2_next;
    st3_t  st3_reg, st3_next;
    st4_t  st4_reg, st4_next;
    st5_t  st5_reg, st5_next;
    st6_t  st6_reg, st6_next;
    st7_t  st7_reg, st7_next;
    st8_t  st8_reg, st8_next;
    st9_t  st9_reg, st9_next;
    st10_t st10_reg, st10_next;
    st11_t st11_reg, st11_next;
    pts_t  st12_reg, st12_next;
    st13_t st13_reg, st13_next;
    st14_t st14_reg, st14_next;
    st15_t st15_reg, st15_next;
    st16_t st16_reg, st16_next;

    logic signed [POINT_W-1:0] point_one_x_reg, point_one_x_next;
    logic signed [POINT_W-1:0] point_one_y_reg, point_one_y_next;
    logic signed [POINT_W-1:0] point_two_x_reg, point_two_x_next;
    logic signed [POINT_W-1:0] point_two_y_reg, point_two_y_next;
    logic [PARAM_W-1:0]        param_first_reg, param_first_next;
    logic [PARAM_W-1:0]        param_second_reg, param_second_next;
    logic [DIST_W-1:0]         dist_squared_reg, dist_squared_next;

    logic          d1_valid, d2_valid, d3_valid;
    logic [F-1:0]  d1_quo, d3_quo;
    logic [QF-1:0] d2_quo;
    side1_t        d1_side;
    side2_t        d2_side;
    side3_t        d3_side;

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        st1_next.g.p1x = first_start_x;
        st1_next.g.p1y = first_start_y;
        st1_next.g.p2x = second_end_x;
        st1_next.g.p2y = second_end_y;
        st1_next.g.d1x = DIFF_W'(first_end_x) - DIFF_W'(first_start_x);
        st1_next.g.d1y = DIFF_W'(first_end_y) - DIFF_W'(first_start_y);
        st1_next.g.d2x = DIFF_W'(second_start_x) - DIFF_W'(second_end_x);
        st1_next.g.d2y = DIFF_W'(second_start_y) - DIFF_W'(second_end_y);
        st1_next.rx = DIFF_W'(first_start_x) - DIFF_W'(second_end_x);
        st1_next.ry = DIFF_W'(first_start_y) - DIFF_W'(second_end_y);
    end

    always_comb
    begin
        st2_next.g = st1_reg.g;
        st2_next.aa1 = st1_reg.g.d1x * st1_reg.g.d1x;
        st2_next.aa2 = st1_reg.g.d1y * st1_reg.g.d1y;
        st2_next.ee1 = st1_reg.g.d2x * st1_reg.g.d2x;
        st2_next.ee2 = st1_reg.g.d2y * st1_reg.g.d2y;
        st2_next.ff1 = st1_reg.g.d2x * st1_reg.rx;
        st2_next.ff2 = st1_reg.g.d2y * st1_reg.ry;
        st2_next.cc1 = st1_reg.g.d1x * st1_reg.rx;
        st2_next.cc2 = st1_reg.g.d1y * st1_reg.ry;
        st2_next.bb1 = st1_reg.g.d1x * st1_reg.g.d2x;
        st2_next.bb2 = st1_reg.g.d1y * st1_reg.g.d2y;
        st2_next.xa = st1_reg.g.d1x * st1_reg.g.d2y;
        st2_next.xb = st1_reg.g.d1y * st1_reg.g.d2x;
        st2_next.ya = st1_reg.g.d2x * st1_reg.ry;
        st2_next.yb = st1_reg.g.d2y * st1_reg.rx;
    end

    always_comb
    begin
        st3_next.g = st2_reg.g;
        st3_next.a = SUM_W'(st2_reg.aa1) + SUM_W'(st2_reg.aa2);
        st3_next.e = SUM_W'(st2_reg.ee1) + SUM_W'(st2_reg.ee2);
        st3_next.f = SUM_W'(st2_reg.ff1) + SUM_W'(st2_reg.ff2);
        st3_next.c = SUM_W'(st2_reg.cc1) + SUM_W'(st2_reg.cc2);
        st3_next.b = SUM_W'(st2_reg.bb1) + SUM_W'(st2_reg.bb2);
        st3_next.cr12 = SUM_W'(st2_reg.xa) - SUM_W'(st2_reg.xb);
        st3_next.cr2r = SUM_W'(st2_reg.ya) - SUM_W'(st2_reg.yb);
    end

    always_comb
    begin
        st4_next.sd.g = st3_reg.g;
        st4_next.sd.a = st3_reg.a;
        st4_next.sd.e = st3_reg.e;
        st4_next.sd.f = st3_reg.f;
        st4_next.sd.c = st3_reg.c;
        st4_next.sd.b = st3_reg.b;
        st4_next.sd.az = (st3_reg.a == '0);
        st4_next.sd.ez = (st3_reg.e == '0);
        if ((st3_reg.a == '0) || (st3_reg.e == '0) || (st3_reg.cr12 == '0))
        begin
            st4_next.sd.kind = QK_ZERO;
        end
        else
        begin
            st4_next.sd.kind = quo_kind_f(st3_reg.cr2r, st3_reg.cr12);
        end
        st4_next.num = {mag_f(st3_reg.cr2r), {F{1'b0}}};
        st4_next.den = mag_f(st3_reg.cr12);
    end

    sscp_div #(
        .DEN_W (MAG_W),
        .QUO_W (F),
        .SIDE_W($bits(side1_t))
    ) u_div_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v4_reg),
        .num      (st4_reg.num),
        .den      (st4_reg.den),
        .side_in  (st4_reg.sd),
        .out_valid(d1_valid),
        .quo      (d1_quo),
        .side_out (d1_side)
    );

    always_comb
    begin
        logic [QF-1:0] s0;
        case (d1_side.kind)
            QK_ZERO: s0 = '0;
            QK_ONE:  s0 = ONE_Q;
            QK_DIV:  s0 = {1'b0, d1_quo};
            default: s0 = '0;
        endcase
        st5_next.g = d1_side.g;
        st5_next.a = d1_side.a;
        st5_next.e = d1_side.e;
        st5_next.c = d1_side.c;
        st5_next.b = d1_side.b;
        st5_next.az = d1_side.az;
        st5_next.ez = d1_side.ez;
        st5_next.s0 = s0;
        st5_next.prod = d1_side.b * $signed({1'b0, s0});
        st5_next.fsh = {d1_side.f, {F{1'b0}}};
    end

    always_comb
    begin
        st6_next.g = st5_reg.g;
        st6_next.a = st5_reg.a;
        st6_next.e = st5_reg.e;
        st6_next.c = st5_reg.c;
        st6_next.b = st5_reg.b;
        st6_next.az = st5_reg.az;
        st6_next.ez = st5_reg.ez;
        st6_next.s0 = st5_reg.s0;
        st6_next.n = NW'(st5_reg.prod) + NW'(st5_reg.fsh);
    end

    always_comb
    begin
        logic signed [NW-1:0] e_w;
        logic signed [NW-1:0] e_hi;
        logic signed [NW-1:0] n_lo;
        logic                 neg;
        logic                 high;
        e_w = NW'(st6_reg.e);
        e_hi = (e_w <<< F) + e_w;
        n_lo = st6_reg.n + e_w;
        neg = st6_reg.n[NW-1];
        high = (st6_reg.n >= e_hi);
        st7_next.sd.g = st6_reg.g;
        st7_next.sd.a = st6_reg.a;
        st7_next.sd.c = st6_reg.c;
        st7_next.sd.b = st6_reg.b;
        st7_next.sd.az = st6_reg.az;
        st7_next.sd.ez = st6_reg.ez;
        st7_next.sd.low = (n_lo <= 0);
        st7_next.sd.high = high;
        st7_next.sd.neg = neg;
        st7_next.sd.s0 = st6_reg.s0;
        st7_next.num = (neg || high) ? '0 : (MAG_W+QF)'(st6_reg.n);
        st7_next.den = MAG_W'(st6_reg.e);
    end

    sscp_div #(
        .DEN_W (MAG_W),
        .QUO_W (QF),
        .SIDE_W($bits(side2_t))
    ) u_div_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v7_reg),
        .num      (st7_reg.num),
        .den      (st7_reg.den),
        .side_in  (st7_reg.sd),
        .out_valid(d2_valid),
        .quo      (d2_quo),
        .side_out (d2_side)
    );

    always_comb
    begin
        logic gen;
        gen = !d2_side.az && !d2_side.ez;
        st8_next.g = d2_side.g;
        st8_next.a = d2_side.a;
        st8_next.s0 = d2_side.s0;
        if (d2_side.ez || d2_side.neg)
        begin
            st8_next.t = '0;
        end
        else if (d2_side.high)
        begin
            st8_next.t = ONE_Q;
        end
        else
        begin
            st8_next.t = d2_quo;
        end
        st8_next.sel3 = (d2_side.ez && !d2_side.az) || (gen && (d2_side.low || d2_side.high));
        st8_next.num3 = (gen && d2_side.high) ? (d2_side.b - d2_side.c) : -d2_side.c;
    end

    always_comb
    begin
        st9_next.sd.g = st8_reg.g;
        st9_next.sd.s0 = st8_reg.s0;
        st9_next.sd.t = st8_reg.t;
        st9_next.sd.sel3 = st8_reg.sel3;
        st9_next.sd.kind = quo_kind_f(st8_reg.num3, st8_reg.a);
        st9_next.num = {mag_f(st8_reg.num3), {F{1'b0}}};
        st9_next.den = mag_f(st8_reg.a);
    end

    sscp_div #(
        .DEN_W (MAG_W),
        .QUO_W (F),
        .SIDE_W($bits(side3_t))
    ) u_div_third (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v9_reg),
        .num      (st9_reg.num),
        .den      (st9_reg.den),
        .side_in  (st9_reg.sd),
        .out_valid(d3_valid),
        .quo      (d3_quo),
        .side_out (d3_side)
    );

    always_comb
    begin
        logic [QF-1:0] s3;
        case (d3_side.kind)
            QK_ZERO: s3 = '0;
            QK_ONE:  s3 = ONE_Q;
            QK_DIV:  s3 = {1'b0, d3_quo};
            default: s3 = '0;
        endcase
        st10_next.g = d3_side.g;
        st10_next.s = d3_side.sel3 ? s3 : d3_side.s0;
        st10_next.t = d3_side.t;
    end

    always_comb
    begin
        st11_next.p1x = st10_reg.g.p1x;
        st11_next.p1y = st10_reg.g.p1y;
        st11_next.p2x = st10_reg.g.p2x;
        st11_next.p2y = st10_reg.g.p2y;
        st11_next.s = st10_reg.s;
        st11_next.t = st10_reg.t;
        st11_next.m1x = st10_reg.g.d1x * $signed({1'b0, st10_reg.s});
        st11_next.m1y = st10_reg.g.d1y * $signed({1'b0, st10_reg.s});
        st11_next.m2x = st10_reg.g.d2x * $signed({1'b0, st10_reg.t});
        st11_next.m2y = st10_reg.g.d2y * $signed({1'b0, st10_reg.t});
    end

    always_comb
    begin
        st12_next.s = st11_reg.s;
        st12_next.t = st11_reg.t;
        st12_next.c1x = (CW'(st11_reg.p1x) <<< F) + CW'(st11_reg.m1x);
        st12_next.c1y = (CW'(st11_reg.p1y) <<< F) + CW'(st11_reg.m1y);
        st12_next.c2x = (CW'(st11_reg.p2x) <<< F) + CW'(st11_reg.m2x);
        st12_next.c2y = (CW'(st11_reg.p2y) <<< F) + CW'(st11_reg.m2y);
    end

    always_comb
    begin
        st13_next.p = st12_reg;
        st13_next.dx = DXW'(st12_reg.c1x) - DXW'(st12_reg.c2x);
        st13_next.dy = DXW'(st12_reg.c1y) - DXW'(st12_reg.c2y);
    end

    always_comb
    begin
        logic signed [DXW-1:0] ndx;
        logic signed [DXW-1:0] ndy;
        logic [DXW-1:0]        ux;
        logic [DXW-1:0]        uy;
        ndx = -st13_reg.dx;
        ndy = -st13_reg.dy;
        ux = st13_reg.dx[DXW-1] ? ndx : st13_reg.dx;
        uy = st13_reg.dy[DXW-1] ? ndy : st13_reg.dy;
        st14_next.p = st13_reg.p;
        st14_next.hx = ux[DXW-1:F];
        st14_next.hy = uy[DXW-1:F];
        st14_next.lx = ux[F-1:0];
        st14_next.ly = uy[F-1:0];
    end

    always_comb
    begin
        st15_next.p = st14_reg.p;
        st15_next.hhx = st14_reg.hx * st14_reg.hx;
        st15_next.hhy = st14_reg.hy * st14_reg.hy;
        st15_next.hlx = st14_reg.hx * st14_reg.lx;
        st15_next.hly = st14_reg.hy * st14_reg.ly;
        st15_next.llx = st14_reg.lx * st14_reg.lx;
        st15_next.lly = st14_reg.ly * st14_reg.ly;
    end

    always_comb
    begin
        st16_next.p = st15_reg.p;
        st16_next.wx = (WW'(st15_reg.hhx) << F) + (WW'(st15_reg.hlx) << 1);
        st16_next.wy = (WW'(st15_reg.hhy) << F) + (WW'(st15_reg.hly) << 1);
        st16_next.lsum = (2*F+1)'(st15_reg.llx) + (2*F+1)'(st15_reg.lly);
    end

    always_comb
    begin
        logic [DSW-1:0] dsum;
        dsum = DSW'(st16_reg.wx) + DSW'(st16_reg.wy) + DSW'(st16_reg.lsum >> F);
        if ((dsum >> DIST_W) != '0)
        begin
            dist_squared_next = '1;
        end
        else
        begin
            dist_squared_next = DIST_W'(dsum);
        end
        point_one_x_next = POINT_W'(st16_reg.p.c1x);
        point_one_y_next = POINT_W'(st16_reg.p.c1y);
        point_two_x_next = POINT_W'(st16_reg.p.c2x);
        point_two_y_next = POINT_W'(st16_reg.p.c2y);
        param_first_next = PARAM_W'(st16_reg.p.s);
        param_second_next = PARAM_W'(st16_reg.p.t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= d1_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= d2_valid;
            v9_reg <= v8_reg;
            v10_reg <= d3_valid;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            v16_reg <= v15_reg;
            out_valid_reg <= v16_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
            st7_reg <= st7_next;
            st8_reg <= st8_next;
            st9_reg <= st9_next;
            st10_reg <= st10_next;
            st11_reg <= st11_next;
            st12_reg <= st12_next;
            st13_reg <= st13_next;
            st14_reg <= st14_next;
            st15_reg <= st15_next;
            st16_reg <= st16_next;
            point_one_x_reg <= point_one_x_next;
            point_one_y_reg <= point_one_y_next;
            point_two_x_reg <= point_two_x_next;
            point_two_y_reg <= point_two_y_next;
            param_first_reg <= param_first_next;
            param_second_reg <= param_second_next;
            dist_squared_reg <= dist_squared_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_one_x = point_one_x_reg;
    assign point_one_y = point_one_y_reg;
    assign point_two_x = point_two_x_reg;
    assign point_two_y = point_two_y_reg;
    assign param_first = param_first_reg;
    assign param_second = param_second_reg;
    assign dist_squared = dist_squared_reg;

endmodule
